[hdl/pld_pkg.sv]
// Package for the pixel lens distortion map: formats, register codes and shared types.
package pld_pkg;

  localparam int PIXEL_FRAC_BITS = 4;
  localparam int NORM_FRAC       = 20;
  localparam int LANES           = 2;

  localparam logic [15:0] FOCAL_RESET = 16'(1 << PIXEL_FRAC_BITS);
  localparam logic [63:0] RND_HALF    = 64'd1 << (NORM_FRAC - 1);
  localparam logic [39:0] NORM_ONE    = 40'd1 << NORM_FRAC;

  // Divider: four quotient bits per stage, 24 bits in all.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 24 / DIV_BITS;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_TAN_P1,
    REG_TAN_P2
  } cfg_reg_e;

  // Coefficient slots
  localparam logic [1:0] CK_K1 = 2'd0;
  localparam logic [1:0] CK_K2 = 2'd1;
  localparam logic [1:0] CK_P1 = 2'd2;
  localparam logic [1:0] CK_P2 = 2'd3;

  typedef struct packed {
    logic [15:0] rem;
    logic [23:0] low;
    logic [23:0] quo;
  } div_t;

  // round(p / 2^20), ties away from zero, on a magnitude; negated when neg
  function automatic logic [63:0] qround(logic [63:0] p, logic neg);
    logic [63:0] r;
    r = (p + RND_HALF) >> NORM_FRAC;
    return neg ? (64'd0 - r) : r;
  endfunction

endpackage

[hdl/pixel_lens_distortion_map.sv]
// Top level of the pixel lens distortion map: Brown-Conrady radial and tangential model.
// Fully pipelined: one point enters per clock when nothing stalls. Stages 1 to 6 divide
// by the focal length, four quotient bits each; the rest evaluate the polynomial with
// at most one multiplier level per stage and map back to pixels. Every stage holds a
// valid bit and moves only when the next one is free, so a stalled output keeps filling
// empty stages upstream and input is refused only once the whole line is full.
// Configuration is taken every cycle.
module pixel_lens_distortion_map import pld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mapped_x_o,
  output logic [15:0] mapped_y_o,
  output logic        clipped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int ST_DIFF = 0;
  localparam int ST_DIV0 = 1;
  localparam int ST_DIVN = ST_DIV0 + DIV_STAGES - 1;
  localparam int ST_NORM = ST_DIVN + 1;
  localparam int ST_SQ   = ST_NORM + 1;
  localparam int ST_SQR  = ST_SQ + 1;
  localparam int ST_SUM  = ST_SQR + 1;
  localparam int ST_MUL2 = ST_SUM + 1;
  localparam int ST_RND2 = ST_MUL2 + 1;
  localparam int ST_TAN  = ST_RND2 + 1;
  localparam int ST_K2R  = ST_TAN + 1;
  localparam int ST_RAD  = ST_K2R + 1;
  localparam int ST_RMAG = ST_RAD + 1;
  localparam int ST_PP   = ST_RMAG + 1;
  localparam int ST_PPS  = ST_PP + 1;
  localparam int ST_U    = ST_PPS + 1;
  localparam int ST_UMAG = ST_U + 1;
  localparam int ST_FPP  = ST_UMAG + 1;
  localparam int ST_FPS  = ST_FPP + 1;
  localparam int ST_PIX  = ST_FPS + 1;
  localparam int ST_OUT  = ST_PIX + 1;
  localparam int NSTG    = ST_OUT + 1;

  // configuration
  logic [15:0] focal_q  [LANES];
  logic [15:0] center_q [LANES];
  logic [23:0] kmag_q   [4];
  logic [3:0]  kneg_q;
  logic [23:0] cmag;

  // handshake
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;

  // stage data
  logic [15:0] pix_w  [LANES];
  logic [16:0] diff_w [LANES];
  div_t        div_in [LANES];

  logic [15:0]      dmag_q [LANES];
  logic [LANES-1:0] sign_q [ST_DIFF:ST_RMAG];
  logic [LANES-1:0] dz_q   [ST_DIFF:ST_DIVN];
  logic [LANES-1:0] ovf_q  [ST_DIV0:ST_DIVN];
  div_t             div_q  [ST_DIV0:ST_DIVN][LANES];
  logic [23:0]      nmag_q [ST_NORM:ST_RMAG][LANES];
  logic [47:0]      sq_q   [3];
  logic [26:0]      x2_q   [LANES];
  logic [26:0]      xym_q  [ST_SQR:ST_SUM];
  logic             xysgn_q [ST_SQR:ST_MUL2];
  logic [27:0]      r2_q;
  logic [28:0]      sx_q   [LANES];
  logic [55:0]      r4p_q;
  logic [51:0]      k1p_q;
  logic [52:0]      tp_q   [4];
  logic [34:0]      r4_q;
  logic [32:0]      k1r2_q [ST_RND2:ST_K2R];
  logic [33:0]      a_q    [4];
  logic [33:0]      tuv_q  [ST_TAN:ST_PPS][LANES];
  logic [58:0]      k2p_q;
  logic [39:0]      k2r4_q;
  logic [39:0]      radial_q;
  logic [38:0]      rmag_q;
  logic             rneg_q;
  logic [43:0]      lo_q   [LANES];
  logic [42:0]      hi_q   [LANES];
  logic [LANES-1:0] pneg_q;
  logic [42:0]      m_q    [LANES];
  logic [LANES-1:0] mneg_q;
  logic [43:0]      u_q    [LANES];
  logic [42:0]      umag_q [LANES];
  logic [LANES-1:0] uneg_q [ST_UMAG:ST_FPS];
  logic [37:0]      flo_q  [LANES];
  logic [36:0]      fhi_q  [LANES];
  logic [39:0]      pm_q   [LANES];
  logic [41:0]      p_q    [LANES];
  logic [15:0]      mapped_q [LANES];
  logic             clip_q;

  function automatic div_t div_step(div_t s, logic [15:0] f);
    logic [16:0] t;
    div_t        r;
    r = s;
    for (int k = 0; k < DIV_BITS; k++) begin
      t     = {r.rem, r.low[23]};
      r.low = {r.low[22:0], 1'b0};
      if (t >= {1'b0, f}) begin
        r.rem = 16'(t - {1'b0, f});
        r.quo = {r.quo[22:0], 1'b1};
      end else begin
        r.rem = t[15:0];
        r.quo = {r.quo[22:0], 1'b0};
      end
    end
    return r;
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_ready_o = 1'b1;
  assign cmag = cfg_data_i[23] ? (~cfg_data_i + 24'd1) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q[0]  <= FOCAL_RESET;
      focal_q[1]  <= FOCAL_RESET;
      center_q[0] <= '0;
      center_q[1] <= '0;
      for (int c = 0; c < 4; c++) kmag_q[c] <= '0;
      kneg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FOCAL_X:   focal_q[0]  <= cfg_data_i[15:0];
        REG_FOCAL_Y:   focal_q[1]  <= cfg_data_i[15:0];
        REG_CENTER_X:  center_q[0] <= cfg_data_i[15:0];
        REG_CENTER_Y:  center_q[1] <= cfg_data_i[15:0];
        REG_RADIAL_K1: begin
          kmag_q[CK_K1] <= cmag;
          kneg_q[CK_K1] <= cfg_data_i[23];
        end
        REG_RADIAL_K2: begin
          kmag_q[CK_K2] <= cmag;
          kneg_q[CK_K2] <= cfg_data_i[23];
        end
        REG_TAN_P1: begin
          kmag_q[CK_P1] <= cmag;
          kneg_q[CK_P1] <= cfg_data_i[23];
        end
        REG_TAN_P2: begin
          kmag_q[CK_P2] <= cmag;
          kneg_q[CK_P2] <= cfg_data_i[23];
        end
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int i = NSTG - 1; i >= 0; i--) rdy[i] = ~v_q[i] | rdy[i+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- combinational stage inputs ----------------
  assign pix_w[0] = pixel_x_i;
  assign pix_w[1] = pixel_y_i;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff_w[l] = {1'b0, pix_w[l]} - {1'b0, center_q[l]};
      div_in[l].rem = {4'd0, dmag_q[l][15:4]};
      div_in[l].low = {dmag_q[l][3:0], 20'(focal_q[l] >> 1)};
      div_in[l].quo = '0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    // pixel minus principal point
    if (rdy[ST_DIFF]) begin
      for (int l = 0; l < LANES; l++) begin
        dmag_q[l]          <= diff_w[l][16] ? 16'(17'd0 - diff_w[l]) : diff_w[l][15:0];
        sign_q[ST_DIFF][l] <= diff_w[l][16];
        dz_q[ST_DIFF][l]   <= (pix_w[l] == center_q[l]);
      end
    end
    for (int k = ST_DIFF + 1; k <= ST_RMAG; k++) begin
      if (rdy[k]) sign_q[k] <= sign_q[k-1];
    end
    for (int k = ST_DIFF + 1; k <= ST_DIVN; k++) begin
      if (rdy[k]) dz_q[k] <= dz_q[k-1];
    end

    // restoring divide by focal length
    if (rdy[ST_DIV0]) begin
      for (int l = 0; l < LANES; l++) begin
        div_q[ST_DIV0][l] <= div_step(div_in[l], focal_q[l]);
        ovf_q[ST_DIV0][l] <= ({4'd0, dmag_q[l][15:4]} >= focal_q[l]);
      end
    end
    for (int k = ST_DIV0 + 1; k <= ST_DIVN; k++) begin
      if (rdy[k]) begin
        ovf_q[k] <= ovf_q[k-1];
        for (int l = 0; l < LANES; l++) div_q[k][l] <= div_step(div_q[k-1][l], focal_q[l]);
      end
    end

    // saturate to Q4.20, kept as magnitude and sign
    if (rdy[ST_NORM]) begin
      for (int l = 0; l < LANES; l++) begin
        if (dz_q[ST_DIVN][l]) begin
          nmag_q[ST_NORM][l] <= '0;
        end else if (sign_q[ST_DIVN][l]) begin
          nmag_q[ST_NORM][l] <= (ovf_q[ST_DIVN][l] || div_q[ST_DIVN][l].quo > 24'h800000) ?
                                24'h800000 : div_q[ST_DIVN][l].quo;
        end else begin
          nmag_q[ST_NORM][l] <= (ovf_q[ST_DIVN][l] || div_q[ST_DIVN][l].quo[23]) ?
                                24'h7FFFFF : div_q[ST_DIVN][l].quo;
        end
      end
    end
    for (int k = ST_NORM + 1; k <= ST_RMAG; k++) begin
      if (rdy[k]) nmag_q[k] <= nmag_q[k-1];
    end

    // x*x, y*y, x*y
    if (rdy[ST_SQ]) begin
      sq_q[0] <= 48'(nmag_q[ST_NORM][0]) * 48'(nmag_q[ST_NORM][0]);
      sq_q[1] <= 48'(nmag_q[ST_NORM][1]) * 48'(nmag_q[ST_NORM][1]);
      sq_q[2] <= 48'(nmag_q[ST_NORM][0]) * 48'(nmag_q[ST_NORM][1]);
    end

    if (rdy[ST_SQR]) begin
      x2_q[0]         <= 27'(qround(64'(sq_q[0]), 1'b0));
      x2_q[1]         <= 27'(qround(64'(sq_q[1]), 1'b0));
      xym_q[ST_SQR]   <= 27'(qround(64'(sq_q[2]), 1'b0));
      xysgn_q[ST_SQR] <= sign_q[ST_SQ][0] ^ sign_q[ST_SQ][1];
    end

    // r2 and r2 + 2*x2, r2 + 2*y2
    if (rdy[ST_SUM]) begin
      r2_q            <= 28'(x2_q[0]) + 28'(x2_q[1]);
      sx_q[0]         <= {1'b0, x2_q[0], 1'b0} + 29'(x2_q[0]) + 29'(x2_q[1]);
      sx_q[1]         <= {1'b0, x2_q[1], 1'b0} + 29'(x2_q[1]) + 29'(x2_q[0]);
      xym_q[ST_SUM]   <= xym_q[ST_SQR];
      xysgn_q[ST_SUM] <= xysgn_q[ST_SQR];
    end

    if (rdy[ST_MUL2]) begin
      r4p_q            <= 56'(r2_q) * 56'(r2_q);
      k1p_q            <= 52'(kmag_q[CK_K1]) * 52'(r2_q);
      tp_q[0]          <= 53'(kmag_q[CK_P1]) * 53'(xym_q[ST_SUM]);
      tp_q[1]          <= 53'(kmag_q[CK_P2]) * 53'(sx_q[0]);
      tp_q[2]          <= 53'(kmag_q[CK_P1]) * 53'(sx_q[1]);
      tp_q[3]          <= 53'(kmag_q[CK_P2]) * 53'(xym_q[ST_SUM]);
      xysgn_q[ST_MUL2] <= xysgn_q[ST_SUM];
    end

    if (rdy[ST_RND2]) begin
      r4_q           <= 35'(qround(64'(r4p_q), 1'b0));
      k1r2_q[ST_RND2] <= 33'(qround(64'(k1p_q), kneg_q[CK_K1]));
      a_q[0] <= 34'(qround(64'(tp_q[0]), kneg_q[CK_P1] ^ xysgn_q[ST_MUL2]));
      a_q[1] <= 34'(qround(64'(tp_q[1]), kneg_q[CK_P2]));
      a_q[2] <= 34'(qround(64'(tp_q[2]), kneg_q[CK_P1]));
      a_q[3] <= 34'(qround(64'(tp_q[3]), kneg_q[CK_P2] ^ xysgn_q[ST_MUL2]));
    end
    for (int k = ST_RND2 + 1; k <= ST_K2R; k++) begin
      if (rdy[k]) k1r2_q[k] <= k1r2_q[k-1];
    end

    // tangential sums, k2*r4
    if (rdy[ST_TAN]) begin
      tuv_q[ST_TAN][0] <= {a_q[0][32:0], 1'b0} + a_q[1];
      tuv_q[ST_TAN][1] <= a_q[2] + {a_q[3][32:0], 1'b0};
      k2p_q            <= 59'(kmag_q[CK_K2]) * 59'(r4_q);
    end
    for (int k = ST_TAN + 1; k <= ST_PPS; k++) begin
      if (rdy[k]) tuv_q[k] <= tuv_q[k-1];
    end

    if (rdy[ST_K2R]) k2r4_q <= 40'(qround(64'(k2p_q), kneg_q[CK_K2]));

    if (rdy[ST_RAD]) radial_q <= NORM_ONE + 40'($signed(k1r2_q[ST_K2R])) + k2r4_q;

    if (rdy[ST_RMAG]) begin
      rmag_q <= radial_q[39] ? 39'(40'd0 - radial_q) : radial_q[38:0];
      rneg_q <= radial_q[39];
    end

    // x * radial in two partial products
    if (rdy[ST_PP]) begin
      for (int l = 0; l < LANES; l++) begin
        lo_q[l]   <= 44'(nmag_q[ST_RMAG][l]) * 44'(rmag_q[19:0]);
        hi_q[l]   <= 43'(nmag_q[ST_RMAG][l]) * 43'(rmag_q[38:20]);
        pneg_q[l] <= sign_q[ST_RMAG][l] ^ rneg_q;
      end
    end

    if (rdy[ST_PPS]) begin
      for (int l = 0; l < LANES; l++) begin
        m_q[l] <= 43'(64'(hi_q[l]) + qround(64'(lo_q[l]), 1'b0));
      end
      mneg_q <= pneg_q;
    end

    if (rdy[ST_U]) begin
      for (int l = 0; l < LANES; l++) begin
        u_q[l] <= (mneg_q[l] ? (44'd0 - 44'(m_q[l])) : 44'(m_q[l]))
                  + 44'($signed(tuv_q[ST_PPS][l]));
      end
    end

    if (rdy[ST_UMAG]) begin
      for (int l = 0; l < LANES; l++) begin
        umag_q[l]          <= u_q[l][43] ? 43'(44'd0 - u_q[l]) : u_q[l][42:0];
        uneg_q[ST_UMAG][l] <= u_q[l][43];
      end
    end
    for (int k = ST_UMAG + 1; k <= ST_FPS; k++) begin
      if (rdy[k]) uneg_q[k] <= uneg_q[k-1];
    end

    // focal * u in two partial products
    if (rdy[ST_FPP]) begin
      for (int l = 0; l < LANES; l++) begin
        flo_q[l] <= 38'(focal_q[l]) * 38'(umag_q[l][21:0]);
        fhi_q[l] <= 37'(focal_q[l]) * 37'(umag_q[l][42:22]);
      end
    end

    if (rdy[ST_FPS]) begin
      for (int l = 0; l < LANES; l++) begin
        pm_q[l] <= 40'(64'({fhi_q[l], 2'b00}) + qround(64'(flo_q[l]), 1'b0));
      end
    end

    if (rdy[ST_PIX]) begin
      for (int l = 0; l < LANES; l++) begin
        p_q[l] <= (uneg_q[ST_FPS][l] ? (42'd0 - 42'(pm_q[l])) : 42'(pm_q[l]))
                  + 42'(center_q[l]);
      end
    end

    // saturate to pixel range
    if (rdy[ST_OUT]) begin
      for (int l = 0; l < LANES; l++) begin
        if (p_q[l][41]) begin
          mapped_q[l] <= '0;
        end else if (|p_q[l][40:16]) begin
          mapped_q[l] <= 16'hFFFF;
        end else begin
          mapped_q[l] <= p_q[l][15:0];
        end
      end
      clip_q <= p_q[0][41] | (|p_q[0][40:16]) | p_q[1][41] | (|p_q[1][40:16]);
    end
  end

  assign mapped_x_o = mapped_q[0];
  assign mapped_y_o = mapped_q[1];
  assign clipped_o  = clip_q;

endmodule
